// ===== rtl/tmtw_pkg.sv =====
// Shared constants for the text mode teletype writer.
package tmtw_pkg;

    // Default geometry and page count
    localparam int PAGES_DEF       = 4;
    localparam int MAX_COLUMNS_DEF = 80;
    localparam int MAX_ROWS_DEF    = 25;

    // Geometry register values after reset
    localparam int COLUMNS_RESET = 80;
    localparam int ROWS_RESET    = 25;

    // Fixed field widths
    localparam int REQ_W     = 2;
    localparam int PAGE_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int CELL_W    = 2 * CHAR_W;
    localparam int CFG_IDX_W = 1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PLACE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BELL      = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LINE_FEED = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0d;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'd1;

endpackage

// ===== rtl/tmtw_ram.sv =====
// Generic simple dual-port RAM with registered read.
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8000,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/text_mode_teletype_writer.sv =====
// Top level of the paged text mode teletype writer.
//
//  channel | direction | handshake          | carries
//  --------+-----------+--------------------+--------------------------------------
//  s_      | in        | s_valid / s_ready  | request type, page, char, attr, cursor
//  m_      | out       | m_valid / m_ready  | read cell, cursor after step, scrolled
//  cfg_    | in        | cfg_wr_en only     | columns_per_row, rows_per_page
//
// Each item passes the sequencer steps lookup, address multiply, execute and output load
// before the next item is accepted; a read adds a step for the registered RAM read.
// A line feed on the last row adds a scroll and a flush step: the scroll moves the page
// one cell per cycle through the single read and single write port of the text RAM.
// After reset a clearing pass writes zero to all PAGES*MAX_COLUMNS*MAX_ROWS cells with
// s_ready low; configuration writes are taken meanwhile. A stalled m_ready holds the
// result in the output register and the sequencer waits.
module text_mode_teletype_writer #(
    parameter int PAGES       = tmtw_pkg::PAGES_DEF,
    parameter int MAX_COLUMNS = tmtw_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tmtw_pkg::MAX_ROWS_DEF,
    localparam int COL_W      = $clog2(MAX_COLUMNS + 1),
    localparam int ROW_W      = $clog2(MAX_ROWS + 1),
    localparam int CFG_W      = (COL_W > ROW_W) ? COL_W : ROW_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [tmtw_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]               cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [tmtw_pkg::REQ_W-1:0]     s_req_type,
    input  logic [tmtw_pkg::PAGE_W-1:0]    s_page,
    input  logic [tmtw_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tmtw_pkg::CHAR_W-1:0]    s_attribute,
    input  logic [COL_W-1:0]               s_column,
    input  logic [ROW_W-1:0]               s_row,
    input  logic                           s_last_of_string,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tmtw_pkg::CHAR_W-1:0]    m_char_read,
    output logic [tmtw_pkg::CHAR_W-1:0]    m_attr_read,
    output logic [COL_W-1:0]               m_cursor_column,
    output logic [ROW_W-1:0]               m_cursor_row,
    output logic                           m_scrolled
);

    import tmtw_pkg::*;

    localparam int CELLS   = PAGES * MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PS_W    = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
    localparam int PIDX_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int COL_RST = (COLUMNS_RESET > MAX_COLUMNS) ? MAX_COLUMNS : COLUMNS_RESET;
    localparam int ROW_RST = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CALC, ST_BASE, ST_EXEC, ST_READ, ST_SCROLL, ST_FLUSH, ST_OUT
    } state_t;

    // Sequencer state
    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_ptr_reg, clr_ptr_next;
    logic              drop_reg, drop_next;

    // Geometry registers
    logic [COL_W-1:0] cfg_cols_reg;
    logic [ROW_W-1:0] cfg_rows_reg;
    logic [COL_W-1:0] cols_eff;
    logic [ROW_W-1:0] rows_eff;

    // Cursor per page
    logic [COL_W-1:0] cur_col_reg [PAGES];
    logic [ROW_W-1:0] cur_row_reg [PAGES];
    logic             cur_we;
    logic [COL_W-1:0] cur_col_new;
    logic [ROW_W-1:0] cur_row_new;

    // Captured item
    logic [REQ_W-1:0]  it_req_reg, it_req_next;
    logic [PAGE_W-1:0] it_page_reg, it_page_next;
    logic [CHAR_W-1:0] it_char_reg, it_char_next;
    logic [CHAR_W-1:0] it_attr_reg, it_attr_next;
    logic [COL_W-1:0]  it_col_reg, it_col_next;
    logic [ROW_W-1:0]  it_row_reg, it_row_next;
    logic              it_last_reg, it_last_next;

    // Working values
    logic [COL_W-1:0]  cols_reg, cols_next;
    logic [ROW_W-1:0]  rows_reg, rows_next;
    logic [COL_W-1:0]  x_reg, x_next;
    logic [ROW_W-1:0]  y_reg, y_next;
    logic [PS_W-1:0]   page_size_reg, page_size_next;
    logic [PS_W-1:0]   row_off_reg, row_off_next;
    logic [PS_W-1:0]   keep_reg, keep_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] off_reg, off_next;

    // Scroll copy
    logic [ADDR_W-1:0] src_ptr_reg, src_ptr_next;
    logic [ADDR_W-1:0] dst_ptr_reg, dst_ptr_next;
    logic [PS_W-1:0]   cnt_reg, cnt_next;
    logic              wr_pend_reg, wr_pend_next;
    logic              wr_zero_reg, wr_zero_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;

    // Pending result and output register
    logic [CHAR_W-1:0] res_char_reg, res_char_next;
    logic [CHAR_W-1:0] res_attr_reg, res_attr_next;
    logic [COL_W-1:0]  res_col_reg, res_col_next;
    logic [ROW_W-1:0]  res_row_reg, res_row_next;
    logic              res_scroll_reg, res_scroll_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_char_reg, m_char_next;
    logic [CHAR_W-1:0] m_attr_reg, m_attr_next;
    logic [COL_W-1:0]  m_col_reg, m_col_next;
    logic [ROW_W-1:0]  m_row_reg, m_row_next;
    logic              m_scroll_reg, m_scroll_next;

    // Text RAM ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    // Combinational helpers
    logic [PIDX_W-1:0] pidx;
    logic              page_ok;
    logic [COL_W-1:0]  cur_x;
    logic [ROW_W-1:0]  cur_y;
    logic [COL_W-1:0]  x_sat;
    logic [ROW_W-1:0]  y_sat;
    logic [ADDR_W-1:0] cell_addr;
    logic [COL_W-1:0]  nx;
    logic [ROW_W-1:0]  ny;
    logic              copying;

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Effective geometry: zero acts as one, oversize saturates
    always_comb begin
        if (cfg_cols_reg == '0) begin
            cols_eff = COL_W'(1);
        end else if (cfg_cols_reg > COL_W'(MAX_COLUMNS)) begin
            cols_eff = COL_W'(MAX_COLUMNS);
        end else begin
            cols_eff = cfg_cols_reg;
        end
        if (cfg_rows_reg == '0) begin
            rows_eff = ROW_W'(1);
        end else if (cfg_rows_reg > ROW_W'(MAX_ROWS)) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = cfg_rows_reg;
        end
    end

    assign pidx      = PIDX_W'(it_page_reg);
    assign page_ok   = (32'(it_page_reg) < PAGES);
    assign cur_x     = cur_col_reg[pidx];
    assign cur_y     = cur_row_reg[pidx];
    assign x_sat     = (cur_x < cols_eff) ? cur_x : cols_eff - COL_W'(1);
    assign y_sat     = (cur_y < rows_eff) ? cur_y : rows_eff - ROW_W'(1);
    assign cell_addr = base_reg + off_reg;
    assign copying   = (cnt_reg < keep_reg);

    // Sequencer next-state logic
    always_comb begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        drop_next       = drop_reg;
        it_req_next     = it_req_reg;
        it_page_next    = it_page_reg;
        it_char_next    = it_char_reg;
        it_attr_next    = it_attr_reg;
        it_col_next     = it_col_reg;
        it_row_next     = it_row_reg;
        it_last_next    = it_last_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        page_size_next  = page_size_reg;
        row_off_next    = row_off_reg;
        keep_next       = keep_reg;
        base_next       = base_reg;
        off_next        = off_reg;
        src_ptr_next    = src_ptr_reg;
        dst_ptr_next    = dst_ptr_reg;
        cnt_next        = cnt_reg;
        wr_pend_next    = 1'b0;
        wr_zero_next    = wr_zero_reg;
        wr_addr_next    = wr_addr_reg;
        res_char_next   = res_char_reg;
        res_attr_next   = res_attr_reg;
        res_col_next    = res_col_reg;
        res_row_next    = res_row_reg;
        res_scroll_next = res_scroll_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_attr_next     = m_attr_reg;
        m_col_next      = m_col_reg;
        m_row_next      = m_row_reg;
        m_scroll_next   = m_scroll_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        cur_we          = 1'b0;
        cur_col_new     = x_reg;
        cur_row_new     = y_reg;
        nx              = x_reg;
        ny              = y_reg;
        s_ready         = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Write stage of the scroll copy, in the cycle after its read
        if (wr_pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_zero_reg ? '0 : mem_rdata;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_ptr_reg;
                mem_wdata    = '0;
                clr_ptr_next = clr_ptr_reg + ADDR_W'(1);
                if (clr_ptr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    it_req_next  = s_req_type;
                    it_page_next = s_page;
                    it_char_next = s_char_code;
                    it_attr_next = s_attribute;
                    it_col_next  = s_column;
                    it_row_next  = s_row;
                    it_last_next = s_last_of_string;
                    state_next   = ST_CALC;
                end
            end
            ST_CALC: begin
                cols_next      = cols_eff;
                rows_next      = rows_eff;
                x_next         = x_sat;
                y_next         = y_sat;
                page_size_next = PS_W'(cols_eff) * PS_W'(rows_eff);
                row_off_next   = PS_W'(y_sat) * PS_W'(cols_eff);
                state_next     = ST_BASE;
            end
            ST_BASE: begin
                base_next  = ADDR_W'(it_page_reg) * ADDR_W'(page_size_reg);
                off_next   = ADDR_W'(row_off_reg) + ADDR_W'(x_reg);
                keep_next  = page_size_reg - PS_W'(cols_reg);
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                res_char_next   = '0;
                res_attr_next   = '0;
                res_scroll_next = 1'b0;
                state_next      = ST_OUT;
                if (!page_ok) begin
                    res_col_next = '0;
                    res_row_next = '0;
                end else begin
                    case (it_req_reg)
                        REQ_WRITE: begin
                            if (drop_reg) begin
                                if (it_last_reg) begin
                                    drop_next = 1'b0;
                                end
                            end else if (it_char_reg == CH_BELL) begin
                                if (!it_last_reg) begin
                                    drop_next = 1'b1;
                                end
                            end else if (it_char_reg == CH_BACKSPACE) begin
                                if (x_reg != '0) begin
                                    nx = x_reg - COL_W'(1);
                                end else if (y_reg != '0) begin
                                    nx = cols_reg - COL_W'(1);
                                    ny = y_reg - ROW_W'(1);
                                end
                            end else if (it_char_reg == CH_LINE_FEED) begin
                                nx = '0;
                                if (y_reg == rows_reg - ROW_W'(1)) begin
                                    // Scroll: copy rows up, then zero the last row
                                    src_ptr_next    = base_reg + ADDR_W'(cols_reg);
                                    dst_ptr_next    = base_reg;
                                    cnt_next        = '0;
                                    res_scroll_next = 1'b1;
                                    state_next      = ST_SCROLL;
                                end else begin
                                    ny = y_reg + ROW_W'(1);
                                end
                            end else if (it_char_reg != CH_RETURN) begin
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr;
                                mem_wdata = {it_attr_reg, it_char_reg};
                                if (x_reg < cols_reg - COL_W'(1)) begin
                                    nx = x_reg + COL_W'(1);
                                end else if (y_reg < rows_reg - ROW_W'(1)) begin
                                    nx = '0;
                                    ny = y_reg + ROW_W'(1);
                                end
                            end
                        end
                        REQ_PLACE: begin
                            nx = (it_col_reg < cols_reg) ? it_col_reg : cols_reg - COL_W'(1);
                            ny = (it_row_reg < rows_reg) ? it_row_reg : rows_reg - ROW_W'(1);
                        end
                        REQ_READ: begin
                            mem_re     = 1'b1;
                            mem_raddr  = cell_addr;
                            state_next = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                    cur_we       = 1'b1;
                    cur_col_new  = nx;
                    cur_row_new  = ny;
                    res_col_next = nx;
                    res_row_next = ny;
                end
            end
            ST_READ: begin
                res_char_next = mem_rdata[CHAR_W-1:0];
                res_attr_next = mem_rdata[CELL_W-1:CHAR_W];
                state_next    = ST_OUT;
            end
            ST_SCROLL: begin
                if (copying) begin
                    mem_re    = 1'b1;
                    mem_raddr = src_ptr_reg;
                end
                wr_pend_next = 1'b1;
                wr_addr_next = dst_ptr_reg;
                wr_zero_next = !copying;
                src_ptr_next = src_ptr_reg + ADDR_W'(1);
                dst_ptr_next = dst_ptr_reg + ADDR_W'(1);
                cnt_next     = cnt_reg + PS_W'(1);
                if (cnt_reg == page_size_reg - PS_W'(1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last pending write goes out this cycle
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_char_next   = res_char_reg;
                    m_attr_next   = res_attr_reg;
                    m_col_next    = res_col_reg;
                    m_row_next    = res_row_reg;
                    m_scroll_next = res_scroll_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            drop_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            drop_reg    <= drop_next;
            wr_pend_reg <= wr_pend_next;
            m_valid_reg <= m_valid_next;
        end
        it_req_reg     <= it_req_next;
        it_page_reg    <= it_page_next;
        it_char_reg    <= it_char_next;
        it_attr_reg    <= it_attr_next;
        it_col_reg     <= it_col_next;
        it_row_reg     <= it_row_next;
        it_last_reg    <= it_last_next;
        cols_reg       <= cols_next;
        rows_reg       <= rows_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        page_size_reg  <= page_size_next;
        row_off_reg    <= row_off_next;
        keep_reg       <= keep_next;
        base_reg       <= base_next;
        off_reg        <= off_next;
        src_ptr_reg    <= src_ptr_next;
        dst_ptr_reg    <= dst_ptr_next;
        cnt_reg        <= cnt_next;
        wr_zero_reg    <= wr_zero_next;
        wr_addr_reg    <= wr_addr_next;
        res_char_reg   <= res_char_next;
        res_attr_reg   <= res_attr_next;
        res_col_reg    <= res_col_next;
        res_row_reg    <= res_row_next;
        res_scroll_reg <= res_scroll_next;
        m_char_reg     <= m_char_next;
        m_attr_reg     <= m_attr_next;
        m_col_reg      <= m_col_next;
        m_row_reg      <= m_row_next;
        m_scroll_reg   <= m_scroll_next;
    end

    // Geometry registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg <= COL_W'(COL_RST);
            cfg_rows_reg <= ROW_W'(ROW_RST);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_COLUMNS: cfg_cols_reg <= cfg_wdata[COL_W-1:0];
                CFG_ROWS:    cfg_rows_reg <= cfg_wdata[ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cursor per page
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PAGES; i++) begin
                cur_col_reg[i] <= '0;
                cur_row_reg[i] <= '0;
            end
        end else if (cur_we) begin
            cur_col_reg[pidx] <= cur_col_new;
            cur_row_reg[pidx] <= cur_row_new;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_char_read     = m_char_reg;
    assign m_attr_read     = m_attr_reg;
    assign m_cursor_column = m_col_reg;
    assign m_cursor_row    = m_row_reg;
    assign m_scrolled      = m_scroll_reg;

    // A scrolled result leaves the cursor at the start of the last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) && m_scroll_reg |->
            (m_col_reg == '0) && (m_row_reg == rows_reg - ROW_W'(1)))
        else $error("scroll result cursor not at start of last row");

    // Result cursor always lies inside the geometry used for the item
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> (m_col_reg < cols_reg) && (m_row_reg < rows_reg))
        else $error("result cursor outside page geometry");

    // No RAM write while waiting for an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("text RAM written while idle");

    // The flush cycle always carries the last copy write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> wr_pend_reg && $past(state_reg == ST_SCROLL))
        else $error("scroll flush without pending write");

endmodule

// ===== sim/tb_text_mode_teletype_writer.sv =====
// Self-checking testbench for the paged text mode teletype writer.
module tb_text_mode_teletype_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tmtw_pkg::*;

    localparam int COL_W      = $clog2(MAX_COLUMNS_DEF + 1);
    localparam int ROW_W      = $clog2(MAX_ROWS_DEF + 1);
    localparam int CFG_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CELL_COUNT = PAGES_DEF * MAX_COLUMNS_DEF * MAX_ROWS_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    // scroll of a full page plus clearing pass fit well inside this
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int PRESSURE_CYCLES = 400;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [PAGE_W-1:0] page;
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] attr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } text_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_rd;
        logic [CHAR_W-1:0] attr_rd;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scrolled;
    } cursor_result_t;

    // DUT signals, inputs known from time zero
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type = '0;
    logic [PAGE_W-1:0]    s_page = '0;
    logic [CHAR_W-1:0]    s_char_code = '0;
    logic [CHAR_W-1:0]    s_attribute = '0;
    logic [COL_W-1:0]     s_column = '0;
    logic [ROW_W-1:0]     s_row = '0;
    logic                 s_last_of_string = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CHAR_W-1:0]    m_char_read;
    logic [CHAR_W-1:0]    m_attr_read;
    logic [COL_W-1:0]     m_cursor_column;
    logic [ROW_W-1:0]     m_cursor_row;
    logic                 m_scrolled;

    // Shadow state of the block
    logic [CELL_W-1:0] text_mem [0:CELL_COUNT-1];
    int                cursor_x [0:PAGES_DEF-1];
    int                cursor_y [0:PAGES_DEF-1];
    bit                bell_drop;
    logic [COL_W-1:0]  columns_reg;
    logic [ROW_W-1:0]  rows_reg;

    text_req_t      pending_requests [$];
    cursor_result_t expected_results [$];
    text_req_t      offered;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit pressure_go = 1'b0;
    bit pressure_done = 1'b0;

    text_mode_teletype_writer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_page           (s_page),
        .s_char_code      (s_char_code),
        .s_attribute      (s_attribute),
        .s_column         (s_column),
        .s_row            (s_row),
        .s_last_of_string (s_last_of_string),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_char_read      (m_char_read),
        .m_attr_read      (m_attr_read),
        .m_cursor_column  (m_cursor_column),
        .m_cursor_row     (m_cursor_row),
        .m_scrolled       (m_scrolled)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Executes one request on the shadow state and returns the cursor result
    function automatic cursor_result_t apply_request(input text_req_t rq);
        cursor_result_t res;
        int cols;
        int rows;
        int base;
        int x;
        int y;
        int n;
        logic [CELL_W-1:0] cell_word;
        res = '0;
        cols = (columns_reg == 0) ? 1 :
               (columns_reg > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(columns_reg);
        rows = (rows_reg == 0) ? 1 :
               (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
        if (int'(rq.page) >= PAGES_DEF) return res;
        base = int'(rq.page) * cols * rows;
        x = (cursor_x[rq.page] >= cols) ? cols - 1 : cursor_x[rq.page];
        y = (cursor_y[rq.page] >= rows) ? rows - 1 : cursor_y[rq.page];
        case (rq.req)
            REQ_WRITE: begin
                if (bell_drop) begin
                    if (rq.last) bell_drop = 1'b0;
                end else if (rq.ch == CH_BELL) begin
                    if (!rq.last) bell_drop = 1'b1;
                end else if (rq.ch == CH_BACKSPACE) begin
                    if (x > 0) begin
                        x--;
                    end else if (y > 0) begin
                        x = cols - 1;
                        y--;
                    end
                end else if (rq.ch == CH_LINE_FEED) begin
                    x = 0;
                    if (y == rows - 1) begin
                        // move page up one row, blank the new bottom row
                        n = cols * (rows - 1);
                        for (int i = 0; i < n; i++) text_mem[base + i] = text_mem[base + cols + i];
                        for (int i = 0; i < cols; i++) text_mem[base + n + i] = '0;
                        res.scrolled = 1'b1;
                    end else begin
                        y++;
                    end
                end else if (rq.ch != CH_RETURN) begin
                    text_mem[base + y * cols + x] = {rq.attr, rq.ch};
                    if (x < cols - 1) begin
                        x++;
                    end else if (y < rows - 1) begin
                        x = 0;
                        y++;
                    end
                end
            end
            REQ_PLACE: begin
                x = (int'(rq.col) >= cols) ? cols - 1 : int'(rq.col);
                y = (int'(rq.row) >= rows) ? rows - 1 : int'(rq.row);
            end
            REQ_READ: begin
                cell_word = text_mem[base + y * cols + x];
                res.char_rd = cell_word[CHAR_W-1:0];
                res.attr_rd = cell_word[CELL_W-1:CHAR_W];
            end
            default: ;
        endcase
        cursor_x[rq.page] = x;
        cursor_y[rq.page] = y;
        res.col = COL_W'(x);
        res.row = ROW_W'(y);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("%0t: result %0d %s: expected %0d, got %0d",
                 $time, results_seen, what, want, got);
    endtask

    task automatic check_result(input cursor_result_t got);
        cursor_result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("arrived with no request pending", 0, 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.char_rd !== want.char_rd) report_mismatch("char_read", want.char_rd, got.char_rd);
        if (got.attr_rd !== want.attr_rd) report_mismatch("attr_read", want.attr_rd, got.attr_rd);
        if (got.col !== want.col) report_mismatch("cursor_column", want.col, got.col);
        if (got.row !== want.row) report_mismatch("cursor_row", want.row, got.row);
        if (got.scrolled !== want.scrolled)
            report_mismatch("scrolled", want.scrolled, got.scrolled);
    endtask

    // Request driver: next item offered once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(), apply_request(offered));
            if (!s_valid || s_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                    offered = pending_requests.pop_front();
                    s_valid          <= 1'b1;
                    s_req_type       <= offered.req;
                    s_page           <= offered.page;
                    s_char_code      <= offered.ch;
                    s_attribute      <= offered.attr;
                    s_column         <= offered.col;
                    s_row            <= offered.row;
                    s_last_of_string <= offered.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result({m_char_read, m_attr_read, m_cursor_column, m_cursor_row,
                              m_scrolled});
                results_seen++;
            end
            if (pressure_go && !pressure_done) begin
                hold_left = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(input logic [REQ_W-1:0] req, input logic [PAGE_W-1:0] page,
                            input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] attr,
                            input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic last);
        text_req_t rq;
        rq = '{req: req, page: page, ch: ch, attr: attr, col: col, row: row, last: last};
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        if (idx == CFG_COLUMNS) columns_reg = value[COL_W-1:0];
        else rows_reg = value[ROW_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every queued item went in and every result came out
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Control characters weighted up, the rest of the byte range random
    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return CH_BELL;
        if (r < 20) return CH_BACKSPACE;
        if (r < 32) return CH_LINE_FEED;
        if (r < 37) return CH_RETURN;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed strings with cursor moves and reads in between
    task automatic queue_random_traffic(input int count);
        int done_cnt;
        int r;
        int len;
        logic [PAGE_W-1:0] pg;
        bit broken;
        done_cnt = 0;
        while (done_cnt < count) begin
            r = $urandom_range(0, 99);
            pg = PAGE_W'($urandom_range(0, 3));
            if (r < 55) begin
                len = $urandom_range(1, 8);
                broken = ($urandom_range(0, 19) == 0);
                for (int k = 0; k < len; k++)
                    push_req(REQ_WRITE, pg, pick_char(), CHAR_W'($urandom_range(0, 255)),
                             COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)),
                             (k == len - 1) && !broken);
                done_cnt += len;
            end else begin
                if (r < 70)
                    push_req(REQ_PLACE, pg, CHAR_W'($urandom_range(0, 255)),
                             CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                             ROW_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                else if (r < 88)
                    push_req(REQ_READ, pg, CHAR_W'($urandom_range(0, 255)),
                             CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                             ROW_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                else if (r < 93)
                    push_req(REQ_UNUSED, pg, CHAR_W'($urandom_range(0, 255)),
                             CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                             ROW_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                else
                    push_req(REQ_W'($urandom_range(0, 3)), pg, CHAR_W'($urandom_range(0, 255)),
                             CHAR_W'($urandom_range(0, 255)), COL_W'($urandom_range(0, 127)),
                             ROW_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                done_cnt++;
            end
        end
    endtask

    task automatic run_phase(input int cols, input int rows, input int count, input bit hold);
        write_cfg(CFG_COLUMNS, CFG_W'(cols));
        write_cfg(CFG_ROWS, CFG_W'(rows));
        queue_random_traffic(count);
        if (hold) pressure_go = 1'b1;
        wait_drained();
    endtask

    // Main sequence
    initial begin
        foreach (text_mem[i]) text_mem[i] = '0;
        foreach (cursor_x[i]) begin
            cursor_x[i] = 0;
            cursor_y[i] = 0;
        end
        bell_drop = 1'b0;
        columns_reg = COL_W'(COLUMNS_RESET);
        rows_reg = ROW_W'(ROWS_RESET);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        snd_idle_pct = 23;
        rcv_idle_pct = 65;

        // Directed part at reset geometry
        push_req(REQ_READ, 2'd0, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        push_req(REQ_WRITE, 2'd0, 8'h41, 8'hff, 7'd0, 5'd0, 1'b1);
        push_req(REQ_WRITE, 2'd0, 8'hff, 8'h00, 7'd127, 5'd31, 1'b1);
        push_req(REQ_WRITE, 2'd0, 8'h00, 8'h5a, 7'd0, 5'd0, 1'b1);
        push_req(REQ_WRITE, 2'd0, CH_RETURN, 8'h00, 7'd0, 5'd0, 1'b1);
        push_req(REQ_WRITE, 2'd0, CH_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b1);
        // backspace at origin stays, at column 0 wraps to previous row
        push_req(REQ_PLACE, 2'd0, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        push_req(REQ_WRITE, 2'd0, CH_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b1);
        push_req(REQ_PLACE, 2'd0, 8'h00, 8'h00, 7'd0, 5'd1, 1'b0);
        push_req(REQ_WRITE, 2'd0, CH_BACKSPACE, 8'h00, 7'd0, 5'd0, 1'b1);
        // saturated placement, write at last cell, scroll moves it up
        push_req(REQ_PLACE, 2'd1, 8'h00, 8'h00, 7'd127, 5'd31, 1'b0);
        push_req(REQ_WRITE, 2'd1, 8'h80, 8'h81, 7'd0, 5'd0, 1'b0);
        push_req(REQ_READ, 2'd1, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        push_req(REQ_WRITE, 2'd1, CH_LINE_FEED, 8'h00, 7'd0, 5'd0, 1'b1);
        push_req(REQ_READ, 2'd1, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        push_req(REQ_PLACE, 2'd1, 8'h00, 8'h00, 7'd79, 5'd23, 1'b0);
        push_req(REQ_READ, 2'd1, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        // bell drop: rest of string ignored, cursor placement unaffected
        push_req(REQ_WRITE, 2'd2, CH_LINE_FEED, 8'h00, 7'd0, 5'd0, 1'b1);
        push_req(REQ_WRITE, 2'd2, CH_BELL, 8'h00, 7'd0, 5'd0, 1'b0);
        push_req(REQ_WRITE, 2'd2, 8'h78, 8'h07, 7'd0, 5'd0, 1'b0);
        push_req(REQ_PLACE, 2'd3, 8'h00, 8'h00, 7'd5, 5'd5, 1'b0);
        push_req(REQ_WRITE, 2'd2, 8'h79, 8'h07, 7'd0, 5'd0, 1'b1);
        push_req(REQ_WRITE, 2'd3, CH_BELL, 8'h00, 7'd0, 5'd0, 1'b1);
        push_req(REQ_WRITE, 2'd3, 8'h7a, 8'h1e, 7'd0, 5'd0, 1'b1);
        push_req(REQ_UNUSED, 2'd3, 8'hff, 8'hff, 7'd127, 5'd31, 1'b1);
        push_req(REQ_PLACE, 2'd3, 8'h00, 8'h00, 7'd5, 5'd5, 1'b0);
        push_req(REQ_READ, 2'd3, 8'h00, 8'h00, 7'd0, 5'd0, 1'b0);
        wait_drained();

        // Random phases across geometries, zero and oversized values included
        run_phase(0, 0, 60, 1'b0);
        run_phase(127, 31, 100, 1'b1);
        run_phase(40, 25, 120, 1'b0);
        snd_idle_pct = 65;
        rcv_idle_pct = 23;
        run_phase(1, 25, 80, 1'b0);
        run_phase(80, 1, 80, 1'b0);
        run_phase(5, 3, 150, 1'b0);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_phase(81, 26, 60, 1'b0);
        run_phase(13, 7, 100, 1'b0);

        // Catch any stray result before the verdict
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tmtw_pkg.sv
rtl/tmtw_ram.sv
rtl/text_mode_teletype_writer.sv
sim/tb_text_mode_teletype_writer.sv
